/* hdl/sest_pkg.sv */
// shared types, codes and helpers of the sensor edge subscription table
// no dependencies; every other file imports this package
package sest_pkg;

  // request kinds
  localparam logic REQ_SUBSCRIBE = 1'b0;
  localparam logic REQ_TICK      = 1'b1;

  // results per tick are capped
  localparam int unsigned MAX_RES = 16;
  localparam int unsigned CNT_W   = 5;

  // slot numbers carried along the chain, wide enough for the largest table
  localparam int unsigned SLOT_W = 6;

  // subscribe result codes
  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2
  } sub_status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BLOCKER  = 2'd0,
    CFG_PUSHER   = 2'd1,
    CFG_ELEVATOR = 2'd2,
    CFG_DOOR     = 2'd3
  } cfg_idx_e;

  // input request
  typedef struct packed {
    logic        req_type;
    logic [4:0]  sensor_sel;
    logic        wanted_level;
    logic [3:0]  signal_id;
    logic        single_fire;
    logic [31:0] sensor_levels;
  } req_t;

  // result item
  typedef struct packed {
    logic [1:0] sub_status;
    logic       fired;
    logic [1:0] signal_index;
    logic [3:0] slot_index;
    logic       last;
  } res_t;

  // configured signal ids
  typedef struct packed {
    logic [3:0] blocker;
    logic [3:0] pusher;
    logic [3:0] elevator;
    logic [3:0] door;
  } ids_t;

  // one subscription
  typedef struct packed {
    logic [4:0] sensor;
    logic       level;
    logic [3:0] sig;
    logic       once;
  } ent_t;

  // scan record handed from cell to cell
  typedef struct packed {
    logic              tok;
    logic              dup_v;
    logic [SLOT_W-1:0] dup_idx;
    logic              free_v;
    logic [SLOT_W-1:0] free_idx;
    logic              pend_v;
    logic [1:0]        pend_sig;
    logic [3:0]        pend_slot;
    logic [CNT_W-1:0]  cnt;
  } carry_t;

  // result pushed out of a cell in mid scan
  typedef struct packed {
    logic valid;
    res_t res;
  } emit_t;

  // slot write after a subscribe scan
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    ent_t              ent;
  } wr_t;

  // signal id lookup result
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } map_t;

  // map a signal id onto an output signal, lowest index wins
  function automatic map_t sig_map(logic [3:0] sig, ids_t ids);
    map_t m;
    m.hit = 1'b1;
    if (sig == ids.blocker) begin
      m.idx = 2'd0;
    end else if (sig == ids.pusher) begin
      m.idx = 2'd1;
    end else if (sig == ids.elevator) begin
      m.idx = 2'd2;
    end else if (sig == ids.door) begin
      m.idx = 2'd3;
    end else begin
      m.hit = 1'b0;
      m.idx = 2'd0;
    end
    return m;
  endfunction

endpackage

/* hdl/sest_cell.sv */
// one slot of the subscription table: holds the entry and its previous level
// and works on the scan record as it passes; depends on sest_pkg
module sest_cell import sest_pkg::*; #(
  parameter int SLOT_NUM    = 0,
  parameter int NUM_SENSORS = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  req_t   req_i,
  input  ids_t   ids_i,
  input  logic   adv_i,
  input  wr_t    wr_i,
  input  carry_t cin_i,
  output carry_t cout_o,
  output emit_t  emit_o
);

  localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(SLOT_NUM);
  localparam logic [3:0]        SLOT_LO = 4'(SLOT_NUM % 16);

  ent_t   ent_q, ent_d;
  logic   prev_q, prev_d;
  carry_t cout_q, cout_d;

  logic   occ;
  logic   cur;
  logic   same;
  map_t   map;

  // slot lookups
  always_comb begin
    occ  = (ent_q.sig != 4'd0);
    cur  = (32'(ent_q.sensor) < NUM_SENSORS) ? req_i.sensor_levels[ent_q.sensor] : 1'b0;
    same = (ent_q.sensor == req_i.sensor_sel) && (ent_q.level == req_i.wanted_level) &&
           (ent_q.sig == req_i.signal_id);
    map  = sig_map(ent_q.sig, ids_i);
  end

  // work on the passing record
  always_comb begin
    cout_d = adv_i ? cin_i : cout_q;
    ent_d  = ent_q;
    prev_d = prev_q;
    emit_o = '0;
    if (adv_i && cin_i.tok) begin
      if (req_i.req_type == REQ_SUBSCRIBE) begin
        if (occ && same && !cin_i.dup_v) begin
          cout_d.dup_v   = 1'b1;
          cout_d.dup_idx = SLOT_ID;
        end
        if (!occ && !cin_i.free_v) begin
          cout_d.free_v   = 1'b1;
          cout_d.free_idx = SLOT_ID;
        end
      end else if (occ && (cur != prev_q)) begin
        prev_d = cur;
        if (cur == ent_q.level) begin
          if (map.hit && (32'(cin_i.cnt) < MAX_RES)) begin
            // older pending firing is not the last one any more
            if (cin_i.pend_v) begin
              emit_o.valid            = 1'b1;
              emit_o.res.sub_status   = ST_ADDED;
              emit_o.res.fired        = 1'b1;
              emit_o.res.signal_index = cin_i.pend_sig;
              emit_o.res.slot_index   = cin_i.pend_slot;
              emit_o.res.last         = 1'b0;
            end
            cout_d.pend_v    = 1'b1;
            cout_d.pend_sig  = map.idx;
            cout_d.pend_slot = SLOT_LO;
            cout_d.cnt       = cin_i.cnt + CNT_W'(1);
          end
          if (ent_q.once) begin
            ent_d = '0;
          end
        end
      end
    end
    // new subscription lands after the scan
    if (wr_i.en && (wr_i.idx == SLOT_ID)) begin
      ent_d = wr_i.ent;
    end
  end

  // slot state and record stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q  <= '0;
      prev_q <= 1'b0;
      cout_q <= '0;
    end else begin
      ent_q  <= ent_d;
      prev_q <= prev_d;
      cout_q <= cout_d;
    end
  end

  assign cout_o = cout_q;

endmodule

/* hdl/sensor_edge_subscription_table_top.sv */
// top level of the sensor edge subscription table: request register, chain of
// slot cells, result collection and output register; depends on sest_pkg, sest_cell
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------
//  in       | in        | in_valid_i/in_ready_o | in_data_i  (req_t)
//  out      | out       | out_valid_o/out_ready_i | out_data_o (res_t)
//  cfg      | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// a request walks the cell chain one slot per cycle while the output does not stall;
// a new request is taken once the previous one has placed its final result in the
// output register. any stall on the output freezes the whole chain.
// reset empties every slot at once and loads the default signal ids.
module sensor_edge_subscription_table_top import sest_pkg::*; #(
  parameter int SLOTS       = 16,
  parameter int NUM_SENSORS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  logic   busy_q, busy_d;
  logic   launch_q, launch_d;
  req_t   req_q;
  ids_t   ids_q, ids_d;
  logic   out_valid_q, out_valid_d;
  res_t   out_q, out_d;

  logic   accept;
  logic   adv;
  logic   fin;
  carry_t chain [SLOTS+1];
  emit_t  emits [SLOTS];
  emit_t  emit_all;
  wr_t    wr;
  res_t   fin_res;

  assign accept = in_valid_i && in_ready_o;
  assign adv    = !out_valid_q || out_ready_i;
  assign fin    = chain[SLOTS].tok && adv;

  // configuration writes
  always_comb begin
    ids_d = ids_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BLOCKER:  ids_d.blocker  = cfg_data_i;
        CFG_PUSHER:   ids_d.pusher   = cfg_data_i;
        CFG_ELEVATOR: ids_d.elevator = cfg_data_i;
        CFG_DOOR:     ids_d.door     = cfg_data_i;
        default:      ids_d          = ids_q;
      endcase
    end
  end

  // request control
  always_comb begin
    busy_d   = busy_q;
    launch_d = launch_q;
    if (adv) begin
      launch_d = 1'b0;
    end
    if (fin) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d   = 1'b1;
      launch_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      ids_q    <= '{blocker: 4'd1, pusher: 4'd2, elevator: 4'd3, door: 4'd4};
    end else begin
      busy_q   <= busy_d;
      launch_q <= launch_d;
      ids_q    <= ids_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
  end

  assign in_ready_o = !busy_q;

  // head of the chain
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = launch_q;
  end

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sest_cell #(
      .SLOT_NUM    (g),
      .NUM_SENSORS (NUM_SENSORS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .ids_i  (ids_q),
      .adv_i  (adv),
      .wr_i   (wr),
      .cin_i  (chain[g]),
      .cout_o (chain[g+1]),
      .emit_o (emits[g])
    );
  end

  // at most one cell holds the token, so the pushes just merge
  always_comb begin
    emit_all = '0;
    for (int i = 0; i < SLOTS; i++) begin
      emit_all = emit_all | emits[i];
    end
  end

  // end of scan: final result and slot write
  always_comb begin
    fin_res  = '0;
    wr       = '0;
    wr.idx   = chain[SLOTS].free_idx;
    wr.ent   = '{sensor: req_q.sensor_sel, level: req_q.wanted_level,
                 sig: req_q.signal_id, once: req_q.single_fire};
    fin_res.last = 1'b1;
    if (req_q.req_type == REQ_TICK) begin
      if (chain[SLOTS].pend_v) begin
        fin_res.fired        = 1'b1;
        fin_res.signal_index = chain[SLOTS].pend_sig;
        fin_res.slot_index   = chain[SLOTS].pend_slot;
      end
    end else if (chain[SLOTS].dup_v) begin
      fin_res.sub_status = ST_DUP;
      fin_res.slot_index = chain[SLOTS].dup_idx[3:0];
    end else if (chain[SLOTS].free_v) begin
      fin_res.sub_status = ST_ADDED;
      fin_res.slot_index = chain[SLOTS].free_idx[3:0];
      wr.en              = fin;
    end else begin
      fin_res.sub_status = ST_FULL;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = fin || emit_all.valid;
      out_d       = fin ? fin_res : emit_all.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/sest_checker.sv */
// port-level checks of the subscription table, bound to the top level
// depends on sest_pkg and sensor_edge_subscription_table_top
module sest_port_checker import sest_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input res_t       out_data_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // firing results always carry the added status code, never duplicate or full
  a_fire_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.sub_status == ST_ADDED)
    else $error("fired result with subscribe status");

  // duplicate or full is a lone final result
  a_sub_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.sub_status == ST_DUP || out_data_o.sub_status == ST_FULL)
    |-> out_data_o.last && !out_data_o.fired)
    else $error("subscribe result not final");

  // no code beyond table full
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sub_status != 2'd3)
    else $error("unknown subscribe status");

endmodule

bind sensor_edge_subscription_table_top sest_port_checker u_sest_checker (.*);
